FILE: rtl/btn_dial_pkg.sv
// ----------------------------------------------------------------------------
// btn_dial_pkg
// Shared types, constants and helpers for the button debounce and dial block.
// ----------------------------------------------------------------------------
package btn_dial_pkg;

  // field widths
  localparam int unsigned RawBits    = 5;
  localparam int unsigned TimeW      = 16;
  localparam int unsigned EventW     = 3;
  localparam int unsigned InDataW    = 24;
  localparam int unsigned OutDataW   = 8;
  localparam int unsigned CfgIndexW  = 1;
  localparam int unsigned DefButtons = 5;

  // button roles
  localparam int unsigned BtnPlus  = 0;
  localparam int unsigned BtnMinus = 1;
  localparam int unsigned BtnNext  = 2;
  localparam int unsigned BtnMode  = 3;

  // hold timer limits and register reset values
  localparam logic [TimeW-1:0] HoldLimit    = 16'd60000;
  localparam logic [TimeW-1:0] HoldMax      = 16'hFFFF;
  localparam logic [TimeW-1:0] DebounceRst  = 16'd20;
  localparam logic [TimeW-1:0] LongPressRst = 16'd1000;

  // dial step count limits (4-bit signed working value)
  localparam logic signed [3:0] DialFull    = 4'sd4;
  localparam logic signed [3:0] DialFullNeg = -4'sd4;

  typedef enum logic [EventW-1:0] {
    EV_NONE      = 3'd0,
    EV_PLUS      = 3'd1,
    EV_MINUS     = 3'd2,
    EV_NEXT      = 3'd3,
    EV_BACK      = 3'd4,
    EV_LONG_NEXT = 3'd5
  } event_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_DEBOUNCE   = 1'b0,
    CFG_LONG_PRESS = 1'b1
  } cfg_reg_e;

  // per-button status handed to the event priority logic
  typedef struct packed {
    logic rise;
    logic long_hit;
  } lane_stat_t;

  // position of a dial line pair in the forward order 00 01 11 10
  function automatic logic [1:0] gray_pos(input logic [1:0] lines);
    logic [1:0] pos;
    unique case (lines)
      2'b00: pos = 2'd0;
      2'b01: pos = 2'd1;
      2'b11: pos = 2'd2;
      2'b10: pos = 2'd3;
      default: pos = 2'd0;
    endcase
    return pos;
  endfunction

endpackage

FILE: rtl/btn_dial_lane.sv
// ----------------------------------------------------------------------------
// btn_dial_lane
// Debounce lane for one button: hold timer, raw and accepted levels.
// ----------------------------------------------------------------------------
module btn_dial_lane #(
  parameter int unsigned Idx = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                upd_i,
  input  logic                                down_i,
  input  logic [btn_dial_pkg::TimeW-1:0]      elapsed_i,
  input  logic [btn_dial_pkg::TimeW-1:0]      debounce_i,
  input  logic [btn_dial_pkg::TimeW-1:0]      long_press_i,
  output btn_dial_pkg::lane_stat_t            stat_o
);

  logic                             prev_q, prev_d;
  logic                             acc_q, acc_d;
  logic [btn_dial_pkg::TimeW-1:0]   timer_q, timer_d;
  logic [btn_dial_pkg::TimeW:0]     grow;
  logic [btn_dial_pkg::TimeW-1:0]   timer_a;
  logic                             take;
  logic                             long_hit;

  // hold timer growth with saturation, restart on raw change
  always_comb begin
    grow   = {1'b0, timer_q} + {1'b0, elapsed_i};
    prev_d = down_i;
    if (down_i == prev_q) begin
      if (timer_q < btn_dial_pkg::HoldLimit) begin
        timer_a = grow[btn_dial_pkg::TimeW] ? btn_dial_pkg::HoldMax
                                            : grow[btn_dial_pkg::TimeW-1:0];
      end else begin
        timer_a = timer_q;
      end
    end else begin
      timer_a = '0;
    end
  end

  // accept level, long press on the next button only
  always_comb begin
    take     = (timer_a >= debounce_i) && (acc_q != down_i);
    acc_d    = take ? down_i : acc_q;
    long_hit = (Idx == btn_dial_pkg::BtnNext) && acc_d && (timer_a >= long_press_i);
    timer_d  = long_hit ? '0 : timer_a;
    stat_o.rise     = take && down_i;
    stat_o.long_hit = long_hit;
  end

  // lane state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b0;
      acc_q   <= 1'b0;
      timer_q <= '0;
    end else if (upd_i) begin
      prev_q  <= prev_d;
      acc_q   <= acc_d;
      timer_q <= timer_d;
    end
  end

endmodule

FILE: rtl/btn_dial_quad.sv
// ----------------------------------------------------------------------------
// btn_dial_quad
// Quadrature dial decoder: counts Gray-code steps, reports full detents.
// ----------------------------------------------------------------------------
module btn_dial_quad (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic upd_i,
  input  logic a_i,
  input  logic b_i,
  output logic plus_o,
  output logic minus_o
);

  logic              prev_a_q, prev_b_q;
  logic signed [2:0] steps_q, steps_d;
  logic [1:0]        was, now, delta;
  logic signed [3:0] dir, sum;
  logic              moved;

  // direction from the position difference, both lines changing counts zero
  always_comb begin
    was   = {prev_a_q, prev_b_q};
    now   = {a_i, b_i};
    moved = (now != was);
    delta = btn_dial_pkg::gray_pos(now) - btn_dial_pkg::gray_pos(was);
    unique case (delta)
      2'd1:    dir = 4'sd1;
      2'd3:    dir = -4'sd1;
      default: dir = 4'sd0;
    endcase
    sum = {steps_q[2], steps_q} + dir;
  end

  // full detent detection
  always_comb begin
    plus_o  = 1'b0;
    minus_o = 1'b0;
    steps_d = steps_q;
    if (moved) begin
      if (sum >= btn_dial_pkg::DialFull) begin
        plus_o  = 1'b1;
        steps_d = '0;
      end else if (sum <= btn_dial_pkg::DialFullNeg) begin
        minus_o = 1'b1;
        steps_d = '0;
      end else begin
        steps_d = sum[2:0];
      end
    end
  end

  // dial state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_a_q <= 1'b0;
      prev_b_q <= 1'b0;
      steps_q  <= '0;
    end else if (upd_i && moved) begin
      prev_a_q <= a_i;
      prev_b_q <= b_i;
      steps_q  <= steps_d;
    end
  end

endmodule

FILE: rtl/button_debounce_and_dial_events_top.sv
// ----------------------------------------------------------------------------
// button_debounce_and_dial_events_top
// Button debounce, long press and quadrature dial events, one event per poll.
// ----------------------------------------------------------------------------
// Each poll item carries the raw button levels, the milliseconds since the
// previous poll and the two dial lines, and yields exactly one event item.
// The block takes one poll per clock cycle unless the result side stalls; a
// poll passes an input register and then a result register, and all button
// lanes and the dial decoder update in parallel in that single pass. A stall
// on the result side holds both registers and lowers s_axis_tready only when
// both are full. Configuration writes should be made while no poll is in
// flight.
module button_debounce_and_dial_events_top #(
  parameter int unsigned Buttons = btn_dial_pkg::DefButtons
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // poll items
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [4:0] buttons_raw, [20:5] elapsed_ms, [21] dial_a, [22] dial_b, [23] zero
  input  logic [btn_dial_pkg::InDataW-1:0]     s_axis_tdata,
  // event items
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [2:0] event_res, [7:3] zero
  output logic [btn_dial_pkg::OutDataW-1:0]    m_axis_tdata,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [btn_dial_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [btn_dial_pkg::TimeW-1:0]       cfg_data_i
);

  logic                                 s1_valid_q;
  logic [btn_dial_pkg::InDataW-1:0]     s1_data_q;
  logic                                 res_valid_q;
  btn_dial_pkg::event_e                 res_event_q, res_event_d;
  logic [btn_dial_pkg::TimeW-1:0]       debounce_q, long_press_q;
  logic                                 advance, upd;
  logic [btn_dial_pkg::RawBits-1:0]     raw;
  logic [btn_dial_pkg::TimeW-1:0]       elapsed;
  btn_dial_pkg::lane_stat_t             stat [Buttons];
  logic                                 dial_plus, dial_minus;

  // handshake and stage control
  assign advance       = !res_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || advance;
  assign upd           = s1_valid_q && advance;

  assign raw     = s1_data_q[btn_dial_pkg::RawBits-1:0];
  assign elapsed = s1_data_q[btn_dial_pkg::RawBits +: btn_dial_pkg::TimeW];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= btn_dial_pkg::DebounceRst;
      long_press_q <= btn_dial_pkg::LongPressRst;
    end else if (cfg_we_i) begin
      unique case (btn_dial_pkg::cfg_reg_e'(cfg_index_i))
        btn_dial_pkg::CFG_DEBOUNCE:   debounce_q   <= cfg_data_i;
        btn_dial_pkg::CFG_LONG_PRESS: long_press_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_data_q <= s_axis_tdata;
    end
  end

  // button lanes, buttons beyond the raw field read as released
  for (genvar i = 0; i < Buttons; i++) begin : g_lane
    logic down;
    if (i < btn_dial_pkg::RawBits) begin : g_raw
      assign down = raw[i];
    end else begin : g_none
      assign down = 1'b0;
    end
    btn_dial_lane #(
      .Idx (i)
    ) u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .upd_i        (upd),
      .down_i       (down),
      .elapsed_i    (elapsed),
      .debounce_i   (debounce_q),
      .long_press_i (long_press_q),
      .stat_o       (stat[i])
    );
  end

  // dial decoder
  btn_dial_quad u_quad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (upd),
    .a_i     (s1_data_q[btn_dial_pkg::RawBits + btn_dial_pkg::TimeW]),
    .b_i     (s1_data_q[btn_dial_pkg::RawBits + btn_dial_pkg::TimeW + 1]),
    .plus_o  (dial_plus),
    .minus_o (dial_minus)
  );

  // event priority: long press, then lowest button, then dial
  always_comb begin
    priority if (stat[btn_dial_pkg::BtnNext].long_hit) begin
      res_event_d = btn_dial_pkg::EV_LONG_NEXT;
    end else if (stat[btn_dial_pkg::BtnPlus].rise) begin
      res_event_d = btn_dial_pkg::EV_PLUS;
    end else if (stat[btn_dial_pkg::BtnMinus].rise) begin
      res_event_d = btn_dial_pkg::EV_MINUS;
    end else if (stat[btn_dial_pkg::BtnNext].rise) begin
      res_event_d = btn_dial_pkg::EV_NEXT;
    end else if (stat[btn_dial_pkg::BtnMode].rise) begin
      res_event_d = btn_dial_pkg::EV_BACK;
    end else if (dial_plus) begin
      res_event_d = btn_dial_pkg::EV_PLUS;
    end else if (dial_minus) begin
      res_event_d = btn_dial_pkg::EV_MINUS;
    end else begin
      res_event_d = btn_dial_pkg::EV_NONE;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      res_event_q <= res_event_d;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {{(btn_dial_pkg::OutDataW - btn_dial_pkg::EventW){1'b0}},
                          res_event_q};

  // checks
  a_event_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:0] <= btn_dial_pkg::EV_LONG_NEXT))
    else $error("event code out of range");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> (s1_valid_q && $stable(s1_data_q)))
    else $error("input stage lost an item under stall");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(s1_valid_q))
    else $error("result appeared without an item in the input stage");

  a_no_take_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && res_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("item taken while both stages are full");

endmodule
